// File: hw/rtl/gdda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date arithmetic package
// Shared types, calendar constants and table functions for the date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdda_pkg;

    // Field widths of the stream items.
    localparam int FUNC_W    = 2;
    localparam int IN_YEAR_W = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int OFF_W     = 20;
    localparam int COUNT_W   = 22;

    // Internal widths: day number accumulator and year register.
    localparam int ACC_W = 26;
    localparam int YR_W  = 16;

    // Days in one 400-year era, one century, one four-year run and one year.
    localparam int DAYS_ERA  = 146097;
    localparam int DAYS_CEN  = 36524;
    localparam int DAYS_QUAD = 1461;
    localparam int DAYS_YEAR = 365;

    localparam int YEARS_ERA  = 400;
    localparam int YEARS_CEN  = 100;
    localparam int YEARS_QUAD = 4;
    localparam int YEARS_ONE  = 1;

    // Day numbers counted from 1 March of year 0.
    localparam logic signed [ACC_W-1:0] Z_FIRST_DAY = ACC_W'(306);    // 0001-01-01
    localparam logic signed [ACC_W-1:0] Z_REPLACE   = ACC_W'(693901); // 1900-01-01

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_SUB  = 2'd1,
        FUNC_DIFF = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_ERA,
        STEP_CEN,
        STEP_QUAD,
        STEP_YEAR,
        STEP_MON
    } step_t;

    typedef enum logic [2:0] {
        OUT_ZERO,
        OUT_DATE,
        OUT_LOW,
        OUT_HIGH,
        OUT_DIFF
    } out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_in;
        logic      fwd_init;
        logic      sel_b;
        step_t     step;
        logic      inv;
        logic      fwd_fin;
        logic      save;
        logic      apply_off;
        logic      inv_init;
        logic      load_out;
        out_kind_t out_kind;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  go;
        logic  below;
        logic  above;
    } dp_sts_t;

    // Month lengths of a common year, index 1 is January.
    localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Length of a month with the leap rule; zero for a month code that is not valid.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            if (m == 4'd0 || m > 4'd12)
            begin
                len = '0;
            end
            else if (m == 4'd2 && leap)
            begin
                len = 5'd29;
            end
            else
            begin
                len = MONTH_LEN[m];
            end
            return len;
        end
    endfunction

    // Offset of the first of a month from 1 March of the same calendar year.
    // January and February lie before that date, so their offsets are negative.
    function automatic logic signed [9:0] month_base(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic signed [9:0] base;
        begin
            case (m)
                4'd1:    base = -10'sd59 - (leap ? 10'sd1 : 10'sd0);
                4'd2:    base = -10'sd28 - (leap ? 10'sd1 : 10'sd0);
                4'd3:    base = 10'sd0;
                4'd4:    base = 10'sd31;
                4'd5:    base = 10'sd61;
                4'd6:    base = 10'sd92;
                4'd7:    base = 10'sd122;
                4'd8:    base = 10'sd153;
                4'd9:    base = 10'sd184;
                4'd10:   base = 10'sd214;
                4'd11:   base = 10'sd245;
                4'd12:   base = 10'sd275;
                default: base = 10'sd0;
            endcase
            return base;
        end
    endfunction

    // Month lengths of a year that starts in March; February comes last.
    function automatic logic [DAY_W-1:0] march_len(input logic [3:0] mp);
        logic [DAY_W-1:0] len;
        begin
            case (mp)
                4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
                4'd11:                  len = 5'd29;
                default:                len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gregorian_date_day_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Gregorian date day arithmetic unit
// Adds or subtracts a day offset to a date, or gives the day count between
// two dates, on streaming channels.
// ----------------------------------------------------------------------------
// Use: a request item enters on the s_axis channel with the operation code
// in tuser and both dates and the offset in tdata; one result item leaves on
// the m_axis channel with the date in tdata and the flags in tuser.
// Dates are turned into day numbers by stepping 400, 100, 4 and 1 years at a
// time through one shared add and compare unit, and back by the same steps
// followed by a walk over the months; each loop ends at the first step that
// is not taken. Operation code three gives a zero result. One item is in
// work at a time, and the next item can be accepted in the cycle after the
// result is loaded. The input is ready again as soon as the result is in
// the output register, so the next item may be taken while the receiver
// stalls; the result stays in place until it is taken. Reset clears the
// controller and drops any item in work; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_day_arithmetic_unit #(
    parameter int MAX_YEAR = 9999
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // year[13:0], month[17:14], day[22:18], day_offset[42:23],
    // other_year[56:43], other_month[60:57], other_day[65:61], zero fill
    input  wire  [71:0] s_axis_tdata,
    // func[1:0]
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // out_year[13:0], out_month[17:14], out_day[22:18], day_count[44:23], zero fill
    output logic [47:0] m_axis_tdata,
    // date_replaced[0], out_of_range[1]
    output logic [1:0]  m_axis_tuser
);

    import gdda_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    logic [IN_YEAR_W-1:0] out_year;
    logic [MONTH_W-1:0]   out_month;
    logic [DAY_W-1:0]     out_day;
    logic [COUNT_W-1:0]   day_count;
    logic                 date_replaced;
    logic                 out_of_range;

    // Sequencer.
    gdda_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    // Arithmetic and result register.
    gdda_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_func        (s_axis_tuser),
        .in_year        (s_axis_tdata[13:0]),
        .in_month       (s_axis_tdata[17:14]),
        .in_day         (s_axis_tdata[22:18]),
        .in_day_offset  (s_axis_tdata[42:23]),
        .in_other_year  (s_axis_tdata[56:43]),
        .in_other_month (s_axis_tdata[60:57]),
        .in_other_day   (s_axis_tdata[65:61]),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .day_count      (day_count),
        .date_replaced  (date_replaced),
        .out_of_range   (out_of_range)
    );

    // Pack the result item.
    assign m_axis_tdata = {3'b000, day_count, out_day, out_month, out_year};
    assign m_axis_tuser = {out_of_range, date_replaced};

endmodule

`default_nettype wire

// File: hw/rtl/gdda_datapath.sv
// ----------------------------------------------------------------------------
// Date unit datapath
// Holds the request, a day number accumulator with one shared add and
// compare step, the year register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_datapath #(
    parameter int MAX_YEAR = 9999
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire gdda_pkg::dp_cmd_t               cmd,
    output gdda_pkg::dp_sts_t                    sts,
    input  wire [gdda_pkg::FUNC_W-1:0]           in_func,
    input  wire [gdda_pkg::IN_YEAR_W-1:0]        in_year,
    input  wire [gdda_pkg::MONTH_W-1:0]          in_month,
    input  wire [gdda_pkg::DAY_W-1:0]            in_day,
    input  wire [gdda_pkg::OFF_W-1:0]            in_day_offset,
    input  wire [gdda_pkg::IN_YEAR_W-1:0]        in_other_year,
    input  wire [gdda_pkg::MONTH_W-1:0]          in_other_month,
    input  wire [gdda_pkg::DAY_W-1:0]            in_other_day,
    output logic [gdda_pkg::IN_YEAR_W-1:0]       out_year,
    output logic [gdda_pkg::MONTH_W-1:0]         out_month,
    output logic [gdda_pkg::DAY_W-1:0]           out_day,
    output logic [gdda_pkg::COUNT_W-1:0]         day_count,
    output logic                                 date_replaced,
    output logic                                 out_of_range
);

    import gdda_pkg::*;

    // Day number of MAX_YEAR-12-31, counted from 1 March of year 0.
    localparam int YOE_MAX = MAX_YEAR % 400;
    localparam int Z_LAST_INT = (MAX_YEAR / 400) * DAYS_ERA + YOE_MAX * DAYS_YEAR
                                + YOE_MAX / 4 - YOE_MAX / 100 + 305;
    localparam logic signed [ACC_W-1:0] Z_LAST = ACC_W'(Z_LAST_INT);
    localparam logic [IN_YEAR_W-1:0] HIGH_YEAR = IN_YEAR_W'(MAX_YEAR % (1 << IN_YEAR_W));

    // Latched request.
    func_t                  func_reg;
    logic [IN_YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]     month_reg;
    logic [DAY_W-1:0]       day_reg;
    logic [OFF_W-1:0]       off_reg;
    logic [IN_YEAR_W-1:0]   oyear_reg;
    logic [MONTH_W-1:0]     omonth_reg;
    logic [DAY_W-1:0]       oday_reg;

    // Working registers.
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] save_reg;
    logic [YR_W-1:0]         yr_reg, yr_next;
    logic [1:0]              cen_reg, cen_next;
    logic [1:0]              one_reg, one_next;
    logic                    quad_reg, quad_next;
    logic [3:0]              mp_reg, mp_next;
    logic                    rep_reg, rep_next;

    // Result register.
    logic [IN_YEAR_W-1:0] out_year_reg;
    logic [MONTH_W-1:0]   out_month_reg;
    logic [DAY_W-1:0]     out_day_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 rep_out_reg;
    logic                 range_reg;

    logic signed [ACC_W-1:0] k_days;
    logic [YR_W-1:0]         k_years;
    logic                    cap_ok;
    logic                    go;

    logic [IN_YEAR_W-1:0]    fy;
    logic [MONTH_W-1:0]      fm;
    logic [DAY_W-1:0]        fd;
    logic                    leap;
    logic                    date_ok;
    logic signed [9:0]       base;
    logic signed [ACC_W-1:0] conv_sum;
    logic signed [ACC_W-1:0] off_ext;

    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] diff_abs;
    logic [COUNT_W-1:0]      diff_sat;

    logic [IN_YEAR_W-1:0] res_year;
    logic [MONTH_W-1:0]   res_month;
    logic [DAY_W-1:0]     res_day;
    logic [COUNT_W-1:0]   res_count;
    logic                 res_range;
    logic [YR_W-1:0]      date_year;

    // Step constants and the shared compare.
    always_comb
    begin
        case (cmd.step)
            STEP_ERA:
            begin
                k_days  = ACC_W'(DAYS_ERA);
                k_years = YR_W'(YEARS_ERA);
                cap_ok  = 1'b1;
            end
            STEP_CEN:
            begin
                k_days  = ACC_W'(DAYS_CEN);
                k_years = YR_W'(YEARS_CEN);
                cap_ok  = (cen_reg != 2'd3);
            end
            STEP_QUAD:
            begin
                k_days  = ACC_W'(DAYS_QUAD);
                k_years = YR_W'(YEARS_QUAD);
                cap_ok  = 1'b1;
            end
            STEP_YEAR:
            begin
                k_days  = ACC_W'(DAYS_YEAR);
                k_years = YR_W'(YEARS_ONE);
                cap_ok  = (one_reg != 2'd3);
            end
            STEP_MON:
            begin
                k_days  = $signed({{(ACC_W-DAY_W){1'b0}}, march_len(mp_reg)});
                k_years = '0;
                cap_ok  = (mp_reg != 4'd11);
            end
            default:
            begin
                k_days  = '0;
                k_years = '0;
                cap_ok  = 1'b0;
            end
        endcase

        if (cmd.step == STEP_NONE)
        begin
            go = 1'b0;
        end
        else if (cmd.inv)
        begin
            go = cap_ok && (acc_reg >= k_days);
        end
        else
        begin
            go = (yr_reg >= k_years);
        end
    end

    // Date check and the month and day part of the day number.
    always_comb
    begin
        fy   = cmd.sel_b ? oyear_reg : year_reg;
        fm   = cmd.sel_b ? omonth_reg : month_reg;
        fd   = cmd.sel_b ? oday_reg : day_reg;
        leap = (one_reg == 2'd0) && (quad_reg || cen_reg == 2'd0);
        date_ok = (fy != '0) && (fd != '0) && (fd <= month_days(fm, leap));
        base = month_base(fm, leap);
        conv_sum = acc_reg + {{(ACC_W-10){base[9]}}, base}
                   + $signed({{(ACC_W-DAY_W){1'b0}}, fd}) - ACC_W'(1);
        off_ext = {{(ACC_W-OFF_W){off_reg[OFF_W-1]}}, off_reg};
    end

    // Next values of the working registers.
    always_comb
    begin
        acc_next  = acc_reg;
        yr_next   = yr_reg;
        cen_next  = cen_reg;
        one_next  = one_reg;
        quad_next = quad_reg;
        mp_next   = mp_reg;
        rep_next  = rep_reg;

        if (cmd.load_in)
        begin
            rep_next = 1'b0;
        end

        if (cmd.fwd_init)
        begin
            acc_next  = '0;
            yr_next   = {{(YR_W-IN_YEAR_W){1'b0}}, cmd.sel_b ? oyear_reg : year_reg};
            cen_next  = '0;
            one_next  = '0;
            quad_next = 1'b0;
        end
        else if (cmd.inv_init)
        begin
            yr_next   = '0;
            cen_next  = '0;
            one_next  = '0;
            mp_next   = '0;
        end
        else if (go)
        begin
            if (cmd.inv)
            begin
                acc_next = acc_reg - k_days;
                yr_next  = yr_reg + k_years;
            end
            else
            begin
                acc_next = acc_reg + k_days;
                yr_next  = yr_reg - k_years;
            end
            case (cmd.step)
                STEP_CEN:  cen_next  = cen_reg + 2'd1;
                STEP_QUAD: quad_next = 1'b1;
                STEP_YEAR: one_next  = one_reg + 2'd1;
                STEP_MON:  mp_next   = mp_reg + 4'd1;
                default:   mp_next   = mp_reg;
            endcase
        end
        else if (cmd.fwd_fin)
        begin
            acc_next = date_ok ? conv_sum : Z_REPLACE;
            rep_next = rep_reg | !date_ok;
        end
        else if (cmd.apply_off)
        begin
            acc_next = (func_reg == FUNC_SUB) ? acc_reg - off_ext : acc_reg + off_ext;
        end
    end

    // Result fields for each kind of outcome.
    always_comb
    begin
        diff      = save_reg - acc_reg;
        diff_abs  = diff[ACC_W-1] ? -diff : diff;
        diff_sat  = (diff_abs > $signed({{(ACC_W-COUNT_W){1'b0}}, COUNT_MAX})) ?
                    COUNT_MAX : diff_abs[COUNT_W-1:0];
        date_year = yr_reg + ((mp_reg >= 4'd10) ? YR_W'(1) : YR_W'(0));

        res_year  = '0;
        res_month = '0;
        res_day   = '0;
        res_count = '0;
        res_range = 1'b0;
        case (cmd.out_kind)
            OUT_DATE:
            begin
                res_year  = date_year[IN_YEAR_W-1:0];
                res_month = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
                res_day   = acc_reg[DAY_W-1:0] + 5'd1;
            end
            OUT_LOW:
            begin
                res_year  = IN_YEAR_W'(1);
                res_month = 4'd1;
                res_day   = 5'd1;
                res_range = 1'b1;
            end
            OUT_HIGH:
            begin
                res_year  = HIGH_YEAR;
                res_month = 4'd12;
                res_day   = 5'd31;
                res_range = 1'b1;
            end
            OUT_DIFF:
            begin
                res_count = diff_sat;
            end
            default:
            begin
                res_range = 1'b0;
            end
        endcase
    end

    // Request latch and payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg   <= func_t'(in_func);
            year_reg   <= in_year;
            month_reg  <= in_month;
            day_reg    <= in_day;
            off_reg    <= in_day_offset;
            oyear_reg  <= in_other_year;
            omonth_reg <= in_other_month;
            oday_reg   <= in_other_day;
        end
        if (cmd.save)
        begin
            save_reg <= acc_reg;
        end
        acc_reg <= acc_next;
        yr_reg  <= yr_next;
        rep_reg <= rep_next;
        if (cmd.load_out)
        begin
            out_year_reg  <= res_year;
            out_month_reg <= res_month;
            out_day_reg   <= res_day;
            count_reg     <= res_count;
            rep_out_reg   <= (cmd.out_kind == OUT_ZERO) ? 1'b0 : rep_reg;
            range_reg     <= res_range;
        end
    end

    // Step counters of the decomposition.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg  <= '0;
            one_reg  <= '0;
            quad_reg <= 1'b0;
            mp_reg   <= '0;
        end
        else
        begin
            cen_reg  <= cen_next;
            one_reg  <= one_next;
            quad_reg <= quad_next;
            mp_reg   <= mp_next;
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts.func  = func_reg;
        sts.go    = go;
        sts.below = (acc_reg < Z_FIRST_DAY);
        sts.above = (acc_reg > Z_LAST);
    end

    assign out_year      = out_year_reg;
    assign out_month     = out_month_reg;
    assign out_day       = out_day_reg;
    assign day_count     = count_reg;
    assign date_replaced = rep_out_reg;
    assign out_of_range  = range_reg;

`ifndef SYNTHESIS
    // The inverse walk only starts on an in-range day number and never goes negative.
    a_inv_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.inv && cmd.step != STEP_NONE) |-> !acc_reg[ACC_W-1])
        else $error("day number negative during inverse stepping");

    // A converted date, replaced or not, is never before 0001-01-01.
    a_conv_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fwd_fin |=> (acc_reg >= Z_FIRST_DAY))
        else $error("converted day number below the first day");

    // A stepped result date has a proper month and day.
    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.out_kind == OUT_DATE) |=>
        (out_month_reg >= 4'd1 && out_month_reg <= 4'd12 && out_day_reg != '0))
        else $error("result date has a bad month or day");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/gdda_ctrl.sv
// ----------------------------------------------------------------------------
// Date unit controller
// Sequences the conversion, offset, range check, inverse walk and result
// hand-off, and drives the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    output gdda_pkg::dp_cmd_t       cmd,
    input  wire gdda_pkg::dp_sts_t  sts
);

    import gdda_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_F_ERA,
        ST_F_CEN,
        ST_F_QUAD,
        ST_F_YEAR,
        ST_F_FIN,
        ST_SAVE,
        ST_OFFSET,
        ST_RANGE,
        ST_I_ERA,
        ST_I_CEN,
        ST_I_QUAD,
        ST_I_YEAR,
        ST_I_MON,
        ST_EMIT
    } state_t;

    state_t    state_reg, state_next;
    logic      sel_reg, sel_next;
    out_kind_t kind_reg, kind_next;
    logic      out_valid_reg, out_valid_next;
    logic      accept;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.step     = STEP_NONE;
        cmd.sel_b    = sel_reg;
        cmd.out_kind = kind_reg;
        accept       = s_axis_tvalid && (state_reg == ST_IDLE);
        cmd.load_in  = accept;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                sel_next = 1'b0;
                if (sts.func == FUNC_NONE)
                begin
                    kind_next  = OUT_ZERO;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.fwd_init = 1'b1;
                    cmd.sel_b    = 1'b0;
                    state_next   = ST_F_ERA;
                end
            end
            ST_F_ERA:
            begin
                cmd.step = STEP_ERA;
                if (!sts.go)
                begin
                    state_next = ST_F_CEN;
                end
            end
            ST_F_CEN:
            begin
                cmd.step = STEP_CEN;
                if (!sts.go)
                begin
                    state_next = ST_F_QUAD;
                end
            end
            ST_F_QUAD:
            begin
                cmd.step = STEP_QUAD;
                if (!sts.go)
                begin
                    state_next = ST_F_YEAR;
                end
            end
            ST_F_YEAR:
            begin
                cmd.step = STEP_YEAR;
                if (!sts.go)
                begin
                    state_next = ST_F_FIN;
                end
            end
            ST_F_FIN:
            begin
                cmd.fwd_fin = 1'b1;
                if (sts.func == FUNC_DIFF)
                begin
                    if (sel_reg)
                    begin
                        kind_next  = OUT_DIFF;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SAVE;
                    end
                end
                else
                begin
                    state_next = ST_OFFSET;
                end
            end
            ST_SAVE:
            begin
                // Keep the first day number and start on the second date.
                cmd.save     = 1'b1;
                cmd.fwd_init = 1'b1;
                cmd.sel_b    = 1'b1;
                sel_next     = 1'b1;
                state_next   = ST_F_ERA;
            end
            ST_OFFSET:
            begin
                cmd.apply_off = 1'b1;
                state_next    = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (sts.below)
                begin
                    kind_next  = OUT_LOW;
                    state_next = ST_EMIT;
                end
                else if (sts.above)
                begin
                    kind_next  = OUT_HIGH;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.inv_init = 1'b1;
                    state_next   = ST_I_ERA;
                end
            end
            ST_I_ERA:
            begin
                cmd.inv  = 1'b1;
                cmd.step = STEP_ERA;
                if (!sts.go)
                begin
                    state_next = ST_I_CEN;
                end
            end
            ST_I_CEN:
            begin
                cmd.inv  = 1'b1;
                cmd.step = STEP_CEN;
                if (!sts.go)
                begin
                    state_next = ST_I_QUAD;
                end
            end
            ST_I_QUAD:
            begin
                cmd.inv  = 1'b1;
                cmd.step = STEP_QUAD;
                if (!sts.go)
                begin
                    state_next = ST_I_YEAR;
                end
            end
            ST_I_YEAR:
            begin
                cmd.inv  = 1'b1;
                cmd.step = STEP_YEAR;
                if (!sts.go)
                begin
                    state_next = ST_I_MON;
                end
            end
            ST_I_MON:
            begin
                cmd.inv  = 1'b1;
                cmd.step = STEP_MON;
                if (!sts.go)
                begin
                    kind_next  = OUT_DATE;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Wait until the result register is free, then hand the item over.
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !m_axis_tready) || cmd.load_out;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 1'b0;
            kind_reg      <= OUT_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_axis_tready))
        else $error("result register loaded while still full");

    // An accepted item closes the input until its result is out.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_START && !s_axis_tready))
        else $error("controller did not start on an accepted item");

    // A result that is not taken stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result item withdrawn before it was taken");
`endif

endmodule

`default_nettype wire

// File: bench/gregorian_date_day_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Gregorian date day arithmetic unit testbench
// Drives request items with calendar edge cases and random dates and offsets,
// predicts each result from a day-number model of the calendar, and compares
// every result item field by field while both channels idle and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_day_arithmetic_unit_tb;

    import gdda_pkg::*;

    localparam int     CLK_PERIOD     = 12;
    localparam int     MAX_YEAR       = 9999;
    localparam longint COUNT_LIMIT    = 4194303;
    localparam int     TIMEOUT_CYCLES = 1000000;
    localparam int     SETTLE_CYCLES  = 200;
    localparam int     HOLD_CYCLES    = 1500;

    // One request item as it enters the block.
    typedef struct {
        func_t                     func;
        logic [IN_YEAR_W-1:0]      year;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic signed [OFF_W-1:0]   offset;
        logic [IN_YEAR_W-1:0]      o_year;
        logic [MONTH_W-1:0]        o_month;
        logic [DAY_W-1:0]          o_day;
    } date_req_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [IN_YEAR_W-1:0] year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [COUNT_W-1:0]   count;
        logic                 replaced;
        logic                 out_of_range;
    } date_res_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;   // year, month, day, day_offset, other date, zero fill
    logic [1:0]  s_axis_tuser  = '0;   // func[1:0]
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [47:0] m_axis_tdata;         // out_year, out_month, out_day, day_count, zero fill
    wire  [1:0]  m_axis_tuser;         // date_replaced[0], out_of_range[1]

    date_res_t due_results[$];
    date_res_t head_result;
    int        fault_count   = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_left     = 0;

    gregorian_date_day_arithmetic_unit #(
        .MAX_YEAR(MAX_YEAR)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------------

    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Zero for a month code outside 1..12, so no day can be valid there.
    function automatic longint month_length(input longint y, input longint m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(input longint y, input longint m, input longint d);
        return (y > 0) && (d >= 1) && (d <= month_length(y, m));
    endfunction

    // Days since 1970-01-01, counting years from March so February falls last.
    function automatic longint serial_day(input longint y, input longint m, input longint d);
        longint yy, era, yoe, doy, doe;
        yy  = (m <= 2) ? y - 1 : y;
        era = (yy >= 0 ? yy : yy - 399) / 400;
        yoe = yy - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic void civil_from_serial(input longint z, output longint y,
                                              output longint m, output longint d);
        longint zz, era, doe, yoe, doy, mp;
        zz  = z + 719468;
        era = (zz >= 0 ? zz : zz - 146096) / 146097;
        doe = zz - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    // Expected result item for one request item.
    function automatic date_res_t calc_date_result(input date_req_t r);
        date_res_t res;
        longint    y, m, d, oy, om, od, off, diff, ry, rm, rd;
        res = '0;
        if (r.func == FUNC_NONE)
        begin
            return res;
        end
        y = r.year;
        m = r.month;
        d = r.day;
        // A bad date is replaced by 1900-01-01 before any arithmetic.
        if (!date_valid(y, m, d))
        begin
            y = 1900;
            m = 1;
            d = 1;
            res.replaced = 1'b1;
        end
        if (r.func == FUNC_DIFF)
        begin
            oy = r.o_year;
            om = r.o_month;
            od = r.o_day;
            if (!date_valid(oy, om, od))
            begin
                oy = 1900;
                om = 1;
                od = 1;
                res.replaced = 1'b1;
            end
            diff = serial_day(y, m, d) - serial_day(oy, om, od);
            if (diff < 0)
            begin
                diff = -diff;
            end
            res.count = (diff > COUNT_LIMIT) ? '1 : diff[COUNT_W-1:0];
        end
        else
        begin
            off = r.offset;
            if (r.func == FUNC_SUB)
            begin
                off = -off;
            end
            civil_from_serial(serial_day(y, m, d) + off, ry, rm, rd);
            // Results beyond the supported years clamp to the nearer end.
            if (ry < 1)
            begin
                res.out_of_range = 1'b1;
                ry = 1;
                rm = 1;
                rd = 1;
            end
            else if (ry > MAX_YEAR)
            begin
                res.out_of_range = 1'b1;
                ry = MAX_YEAR;
                rm = 12;
                rd = 31;
            end
            res.year  = ry[IN_YEAR_W-1:0];
            res.month = rm[MONTH_W-1:0];
            res.day   = rd[DAY_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic date_req_t date_request(input func_t f, input int y, input int m,
                                               input int d, input int off, input int oy,
                                               input int om, input int od);
        date_req_t r;
        r.func    = f;
        r.year    = y[IN_YEAR_W-1:0];
        r.month   = m[MONTH_W-1:0];
        r.day     = d[DAY_W-1:0];
        r.offset  = off[OFF_W-1:0];
        r.o_year  = oy[IN_YEAR_W-1:0];
        r.o_month = om[MONTH_W-1:0];
        r.o_day   = od[DAY_W-1:0];
        return r;
    endfunction

    // Mostly valid dates, most of them in early years; some raw field values.
    function automatic void pick_date(output logic [IN_YEAR_W-1:0] y,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            y = IN_YEAR_W'($urandom);
            m = MONTH_W'($urandom);
            d = DAY_W'($urandom);
        end
        else
        begin
            if (sel < 70)
            begin
                y = IN_YEAR_W'($urandom_range(2500, 1));
            end
            else if (sel < 93)
            begin
                y = IN_YEAR_W'($urandom_range(MAX_YEAR, 1));
            end
            else
            begin
                y = IN_YEAR_W'($urandom_range(16383, 1));
            end
            m = MONTH_W'($urandom_range(12, 1));
            d = DAY_W'($urandom_range(int'(month_length(y, m)), 1));
        end
    endfunction

    function automatic date_req_t random_request();
        date_req_t r;
        int        sel;
        sel = $urandom_range(99);
        if (sel < 4)
        begin
            r.func = FUNC_NONE;
        end
        else if (sel < 36)
        begin
            r.func = FUNC_ADD;
        end
        else if (sel < 68)
        begin
            r.func = FUNC_SUB;
        end
        else
        begin
            r.func = FUNC_DIFF;
        end
        pick_date(r.year, r.month, r.day);
        pick_date(r.o_year, r.o_month, r.o_day);
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            r.offset = OFF_W'($urandom_range(800) - 400);
        end
        else if (sel < 75)
        begin
            r.offset = OFF_W'($urandom_range(100000) - 50000);
        end
        else
        begin
            r.offset = OFF_W'($urandom);
        end
        return r;
    endfunction

    // Offers one item, called and returning at a falling edge.
    task automatic send_item(input date_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {6'b0, r.o_day, r.o_month, r.o_year, r.offset,
                         r.day, r.month, r.year};
        s_axis_tuser  = r.func;
        s_axis_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        due_results.push_back(calc_date_result(r));
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Receiver readiness; a requested hold-off is counted down here.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left     = hold_left - 1;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic report_fault(input string what, input longint want, input longint got);
        fault_count = fault_count + 1;
        if (fault_count <= 10)
        begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            report_fault(what, want, got);
        end
    endtask

    // Each accepted result item against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                report_fault("result item with none pending", 0, m_axis_tdata[22:0]);
            end
            else
            begin
                head_result = due_results.pop_front();
                check_field("out_year", head_result.year, m_axis_tdata[13:0]);
                check_field("out_month", head_result.month, m_axis_tdata[17:14]);
                check_field("out_day", head_result.day, m_axis_tdata[22:18]);
                check_field("day_count", head_result.count, m_axis_tdata[44:23]);
                check_field("fill bits", 0, m_axis_tdata[47:45]);
                check_field("date_replaced", head_result.replaced, m_axis_tuser[0]);
                check_field("out_of_range", head_result.out_of_range, m_axis_tuser[1]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Leap rules, month and year boundaries, clamping, replacement, saturation.
    task automatic test_calendar_edges;
        send_idle_pct = 26;
        recv_idle_pct = 56;
        send_item(date_request(FUNC_ADD, 2000, 2, 29, 0, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 1999, 12, 31, 1, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 1900, 2, 28, 1, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 2000, 2, 28, 1, 0, 0, 0));
        send_item(date_request(FUNC_SUB, 2024, 3, 1, 1, 0, 0, 0));
        send_item(date_request(FUNC_SUB, 1, 1, 1, 1, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 9999, 12, 31, 1, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 1, 1, 1, 524287, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 9999, 12, 31, -524288, 0, 0, 0));
        send_item(date_request(FUNC_SUB, 5000, 6, 15, -524288, 0, 0, 0));
        send_item(date_request(FUNC_SUB, 2023, 1, 15, -30, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 16383, 12, 31, 0, 0, 0, 0));
        // Invalid first dates: zero year, bad months, bad days.
        send_item(date_request(FUNC_ADD, 0, 6, 10, 5, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 2001, 0, 10, 5, 0, 0, 0));
        send_item(date_request(FUNC_SUB, 2001, 13, 10, 5, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 2001, 15, 31, 0, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 2001, 5, 0, 0, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 2001, 4, 31, 0, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 1900, 2, 29, 0, 0, 0, 0));
        send_item(date_request(FUNC_ADD, 2000, 2, 30, 0, 0, 0, 0));
        // Differences: equal, full range, saturating, reversed, bad second date.
        send_item(date_request(FUNC_DIFF, 2020, 7, 4, 0, 2020, 7, 4));
        send_item(date_request(FUNC_DIFF, 1, 1, 1, 0, 9999, 12, 31));
        send_item(date_request(FUNC_DIFF, 16383, 12, 31, 0, 1, 1, 1));
        send_item(date_request(FUNC_DIFF, 1900, 3, 1, 0, 2000, 3, 1));
        send_item(date_request(FUNC_DIFF, 2010, 10, 10, 0, 2010, 2, 30));
        send_item(date_request(FUNC_NONE, 16383, 15, 31, -1, 16383, 15, 31));
    endtask

    // Random items under three idling patterns, the last with no idling.
    task automatic test_random_traffic;
        int send_pct [3] = '{26, 56, 0};
        int recv_pct [3] = '{56, 26, 0};
        int p, i;
        for (p = 0; p < 3; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            for (i = 0; i < 260; i++)
            begin
                send_item(random_request());
            end
        end
    endtask

    // Receiver holds off for a long stretch while items keep being offered.
    task automatic test_output_stall;
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        for (i = 0; i < 12; i++)
        begin
            send_item(random_request());
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_calendar_edges();
        test_output_stall();
        test_random_traffic();
        s_axis_tvalid = 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("gregorian_date_day_arithmetic_unit: match");
        end
        else
        begin
            $display("gregorian_date_day_arithmetic_unit: mismatch");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("gregorian_date_day_arithmetic_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/gdda_pkg.sv
hw/rtl/gdda_datapath.sv
hw/rtl/gdda_ctrl.sv
hw/rtl/gregorian_date_day_arithmetic_unit.sv
bench/gregorian_date_day_arithmetic_unit_tb.sv
